[rtl/plist_pkg.sv]
// Package for the positional list engine.
// Holds operation and status codes, size limits and the cell control struct.
// No dependencies.
package plist_pkg;

	// default and largest supported list depth
	localparam int DEPTH_DEF = 16;
	localparam int DEPTH_MAX = 256;

	// field widths fixed by the interface
	localparam int OP_W     = 3;
	localparam int VAL_W    = 32;
	localparam int POS_W    = 8;
	localparam int STATUS_W = 2;
	localparam int FIDX_W   = 4;
	localparam int LEN_W    = 5;

	// width of a count that can hold DEPTH_MAX
	localparam int CNT_MAX_W = $clog2(DEPTH_MAX + 1);

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_BACK  = 3'd0,
		OP_PUSH_FRONT = 3'd1,
		OP_INSERT     = 3'd2,
		OP_POP_FRONT  = 3'd3,
		OP_POP_BACK   = 3'd4,
		OP_ERASE      = 3'd5,
		OP_SEARCH     = 3'd6
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// broadcast to every cell of the chain in each cycle
	typedef struct packed {
		logic                 ins;    // open a gap at idx and store value
		logic                 del;    // close the gap at idx
		logic [POS_W-1:0]     idx;    // target index
		logic [CNT_MAX_W-1:0] count;  // current number of entries
		logic [VAL_W-1:0]     value;  // value to store or compare
	} cell_ctrl_t;

endpackage

[rtl/plist_cell.sv]
// One storage cell of the list chain: holds one entry, shifts to or from
// its neighbors on insert and erase, and compares against a search value.
// Depends on plist_pkg.
module plist_cell import plist_pkg::*; #(
	parameter int IDX = 0
) (
	input  logic             clk,
	input  cell_ctrl_t       ctrl,
	input  logic [VAL_W-1:0] left_data,
	input  logic [VAL_W-1:0] right_data,
	output logic [VAL_W-1:0] data,
	output logic             match
);

	logic [VAL_W-1:0] data_q;
	logic [VAL_W-1:0] data_d;

	// next entry: shift right behind an insert, shift left behind an erase
	always_comb begin
		data_d = data_q;
		if (ctrl.ins) begin
			if (POS_W'(IDX) > ctrl.idx) begin
				data_d = left_data;
			end else if (POS_W'(IDX) == ctrl.idx) begin
				data_d = ctrl.value;
			end
		end else if (ctrl.del) begin
			if (POS_W'(IDX) >= ctrl.idx) begin
				data_d = right_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	// only occupied entries may match
	assign match = (data_q == ctrl.value) && (CNT_MAX_W'(IDX) < ctrl.count);
	assign data  = data_q;

endmodule

[rtl/positional_list_engine_top.sv]
// Top level of the positional list engine: a chain of entry cells, the
// operation decode, a compare stage and the result register.
// Depends on plist_pkg and plist_cell.

// The list lives in a row of DEPTH cells, one entry each, that shift all at
// once, so every operation changes the list at the edge that accepts it and
// the next operation sees the new contents. One item is accepted per cycle
// while in_stall is low. One stage, loaded at the accepting edge, registers
// the per-cell compare results; the next turns them into the first matching
// index and holds the result, which out_valid then offers. A stalled output
// backs up into the input only once both stages are full. No clearing pass
// is needed after reset: entries beyond the length are never read.
module positional_list_engine_top import plist_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [OP_W-1:0]     operation,
	input  logic signed [VAL_W-1:0] value,
	input  logic [POS_W-1:0]    position,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [STATUS_W-1:0] status,
	output logic                found,
	output logic [FIDX_W-1:0]   found_index,
	output logic [LEN_W-1:0]    length
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int WW = (CW > POS_W) ? CW : POS_W;

	logic [CW-1:0] count_q;
	logic [CW-1:0] count_d;
	logic          in_acc;
	logic          adv_s1;

	// stage 1
	logic             valid_s1;
	logic [STATUS_W-1:0] status_s1;
	logic [CW-1:0]    count_s1;
	logic [DEPTH-1:0] match_s1;

	// output register
	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic                found_q;
	logic [FIDX_W-1:0]   found_index_q;
	logic [LEN_W-1:0]    length_q;

	cell_ctrl_t       ctrl;
	status_t          status_d;
	logic [DEPTH-1:0] match;
	logic [VAL_W-1:0] cell_data [DEPTH];
	logic [WW-1:0]    pos_w;
	logic [WW-1:0]    cnt_w;
	logic [WW-1:0]    last_w;
	logic [WW-1:0]    ins_at;
	logic [WW-1:0]    del_at;
	logic             is_full;
	logic             is_empty;
	logic [IW-1:0]    first_idx;

	assign adv_s1   = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !adv_s1;
	assign in_acc   = in_valid && !in_stall;

	assign pos_w    = WW'(position);
	assign cnt_w    = WW'(count_q);
	assign last_w   = cnt_w - WW'(1);
	assign ins_at   = (pos_w >= cnt_w) ? cnt_w : pos_w;
	assign del_at   = (pos_w >= last_w) ? last_w : pos_w;
	assign is_full  = (count_q == CW'(DEPTH));
	assign is_empty = (count_q == '0);

	// operation decode into cell controls, new length and status
	always_comb begin
		ctrl       = '0;
		ctrl.value = value;
		ctrl.count = CNT_MAX_W'(count_q);
		count_d    = count_q;
		status_d   = ST_DONE;
		unique case (operation)
			OP_PUSH_BACK, OP_PUSH_FRONT, OP_INSERT: begin
				if (is_full) begin
					status_d = ST_FULL;
				end else begin
					ctrl.ins = in_acc;
					count_d  = count_q + CW'(1);
					if (operation == OP_PUSH_BACK) begin
						ctrl.idx = POS_W'(cnt_w);
					end else if (operation == OP_PUSH_FRONT) begin
						ctrl.idx = '0;
					end else begin
						ctrl.idx = POS_W'(ins_at);
					end
				end
			end
			OP_POP_FRONT, OP_POP_BACK, OP_ERASE: begin
				if (is_empty) begin
					status_d = ST_EMPTY;
				end else begin
					ctrl.del = in_acc;
					count_d  = count_q - CW'(1);
					if (operation == OP_POP_FRONT) begin
						ctrl.idx = '0;
					end else if (operation == OP_POP_BACK) begin
						ctrl.idx = POS_W'(last_w);
					end else begin
						ctrl.idx = POS_W'(del_at);
					end
				end
			end
			default: begin
				// search and the unused code leave the list alone
			end
		endcase
	end

	// the chain of cells
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [VAL_W-1:0] left_d;
		logic [VAL_W-1:0] right_d;
		if (i == 0) begin : g_first
			assign left_d = value;
		end else begin : g_mid_l
			assign left_d = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_d = cell_data[i];
		end else begin : g_mid_r
			assign right_d = cell_data[i+1];
		end
		plist_cell #(.IDX(i)) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.left_data  (left_d),
			.right_data (right_d),
			.data       (cell_data[i]),
			.match      (match[i])
		);
	end

	// length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (in_acc) begin
			count_q <= count_d;
		end
	end

	// stage 1: registered compare results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			status_s1 <= status_d;
			count_s1  <= count_d;
			match_s1  <= (operation == OP_SEARCH) ? match : '0;
		end
	end

	// first match, lowest index wins
	always_comb begin
		first_idx = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (match_s1[i]) begin
				first_idx = IW'(i);
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1) begin
			status_q      <= status_s1;
			found_q       <= |match_s1;
			found_index_q <= FIDX_W'(first_idx);
			length_q      <= LEN_W'(count_s1);
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign found       = found_q;
	assign found_index = found_index_q;
	assign length      = length_q;

endmodule

[rtl/plist_chk.sv]
// Port-level checker for the positional list engine, bound to the top level.
// Depends on plist_pkg and positional_list_engine_top.
module plist_chk import plist_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_stall,
	input logic [STATUS_W-1:0] status,
	input logic                found,
	input logic [FIDX_W-1:0]   found_index,
	input logic [LEN_W-1:0]    length
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(status) && $stable(found)
			&& $stable(found_index) && $stable(length))
		else $error("stalled result changed");

	// a hit only comes from a search, which always completes
	a_found_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> status == ST_DONE)
		else $error("found set on a failed operation");

	// a miss reports index zero
	a_miss_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> found_index == '0)
		else $error("nonzero index without a match");

	// length never exceeds the capacity (when the port can show it)
	a_len_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (DEPTH < 32) |-> 32'(length) <= 32'(DEPTH))
		else $error("length beyond capacity");

endmodule

bind positional_list_engine_top plist_chk #(.DEPTH(DEPTH)) u_plist_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.status      (status),
	.found       (found),
	.found_index (found_index),
	.length      (length)
);

[sim/tb.sv]
// Self-checking testbench for positional_list_engine_top.
// Predicts results from a shadow copy of the list or takes them from the directed table, checks each result transfer.
// Depends on plist_pkg and the RTL under rtl/.
module tb;
	import plist_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIST_DEPTH = DEPTH_DEF;
	localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
	localparam int RANDOM_ITEMS = 2000;
	localparam int HOLD_AFTER = 700;
	localparam int HOLD_CYCLES = 80;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                found;
		logic [FIDX_W-1:0]   fidx;
		logic [LEN_W-1:0]    len;
	} list_result_t;

	// one directed row; reps > 1 repeats the row with value + repeat index
	typedef struct packed {
		logic [OP_W-1:0]     op;
		logic [VAL_W-1:0]    val;
		logic [POS_W-1:0]    pos;
		logic [4:0]          reps;
		logic                fixed_exp;
		logic [STATUS_W-1:0] st;
		logic                fnd;
		logic [FIDX_W-1:0]   fidx;
		logic [LEN_W-1:0]    len;
	} dir_row_t;

	localparam dir_row_t DIR_TABLE [25] = '{
		// empty list: pops and erase are ignored, search finds nothing, the unused code does nothing
		'{OP_POP_FRONT,  32'h0,        8'd0,   5'd1,  1'b1, ST_EMPTY, 1'b0, 4'd0,  5'd0},
		'{OP_POP_BACK,   32'h0,        8'd0,   5'd1,  1'b1, ST_EMPTY, 1'b0, 4'd0,  5'd0},
		'{OP_ERASE,      32'h0,        8'd255, 5'd1,  1'b1, ST_EMPTY, 1'b0, 4'd0,  5'd0},
		'{OP_SEARCH,     32'h0,        8'd0,   5'd1,  1'b1, ST_DONE,  1'b0, 4'd0,  5'd0},
		'{OP_UNUSED,     32'hFFFFFFFF, 8'd255, 5'd1,  1'b1, ST_DONE,  1'b0, 4'd0,  5'd0},
		// value extremes at both ends
		'{OP_PUSH_BACK,  32'h7FFFFFFF, 8'd0,   5'd1,  1'b1, ST_DONE,  1'b0, 4'd0,  5'd1},
		'{OP_PUSH_FRONT, 32'h80000000, 8'd0,   5'd1,  1'b1, ST_DONE,  1'b0, 4'd0,  5'd2},
		// insert past the end, at the front, in the middle, then searches
		'{OP_INSERT,     32'hFFFFFFFF, 8'd255, 5'd1,  1'b0, ST_DONE,  1'b0, 4'd0,  5'd0},
		'{OP_INSERT,     32'h0,        8'd0,   5'd1,  1'b0, ST_DONE,  1'b0, 4'd0,  5'd0},
		'{OP_INSERT,     32'h5,        8'd2,   5'd1,  1'b0, ST_DONE,  1'b0, 4'd0,  5'd0},
		'{OP_SEARCH,     32'h80000000, 8'd0,   5'd1,  1'b0, ST_DONE,  1'b0, 4'd0,  5'd0},
		'{OP_SEARCH,     32'hFFFFFFFF, 8'd0,   5'd1,  1'b0, ST_DONE,  1'b0, 4'd0,  5'd0},
		'{OP_SEARCH,     32'd12345,    8'd0,   5'd1,  1'b0, ST_DONE,  1'b0, 4'd0,  5'd0},
		// erase front and middle, then the pops
		'{OP_ERASE,      32'h0,        8'd0,   5'd1,  1'b0, ST_DONE,  1'b0, 4'd0,  5'd0},
		'{OP_ERASE,      32'h0,        8'd1,   5'd1,  1'b0, ST_DONE,  1'b0, 4'd0,  5'd0},
		'{OP_POP_BACK,   32'h0,        8'd0,   5'd1,  1'b0, ST_DONE,  1'b0, 4'd0,  5'd0},
		'{OP_POP_FRONT,  32'h0,        8'd0,   5'd1,  1'b0, ST_DONE,  1'b0, 4'd0,  5'd0},
		// erase of the only entry, position far past the end
		'{OP_ERASE,      32'h0,        8'd200, 5'd1,  1'b1, ST_DONE,  1'b0, 4'd0,  5'd0},
		// fill to capacity, then every push kind is dropped and a search finds the last entry
		'{OP_PUSH_BACK,  32'd100,      8'd0,   5'd16, 1'b0, ST_DONE,  1'b0, 4'd0,  5'd0},
		'{OP_PUSH_BACK,  32'd1,        8'd0,   5'd1,  1'b1, ST_FULL,  1'b0, 4'd0,  5'd16},
		'{OP_PUSH_FRONT, 32'd2,        8'd0,   5'd1,  1'b1, ST_FULL,  1'b0, 4'd0,  5'd16},
		'{OP_INSERT,     32'd3,        8'd3,   5'd1,  1'b1, ST_FULL,  1'b0, 4'd0,  5'd16},
		'{OP_SEARCH,     32'd115,      8'd0,   5'd1,  1'b1, ST_DONE,  1'b1, 4'd15, 5'd16},
		// erase at exactly the last index
		'{OP_ERASE,      32'h0,        8'd15,  5'd1,  1'b0, ST_DONE,  1'b0, 4'd0,  5'd0},
		'{OP_ERASE,      32'h0,        8'd14,  5'd1,  1'b0, ST_DONE,  1'b0, 4'd0,  5'd0}
	};

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_stall;
	logic [OP_W-1:0]         operation;
	logic signed [VAL_W-1:0] value;
	logic [POS_W-1:0]        position;
	logic                    out_valid;
	logic                    out_stall;
	logic [STATUS_W-1:0]     status;
	logic                    found;
	logic [FIDX_W-1:0]       found_index;
	logic [LEN_W-1:0]        length;

	// shadow list and the results it predicts
	logic signed [VAL_W-1:0] shadow_entries [LIST_DEPTH];
	int                      shadow_len;
	list_result_t            pending_results [$];
	int                      mismatch_count;
	int                      items_accepted;
	int                      burst_left;
	bit                      rx_holding;

	positional_list_engine_top #(.DEPTH(LIST_DEPTH)) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.operation  (operation),
		.value      (value),
		.position   (position),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.found      (found),
		.found_index(found_index),
		.length     (length)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// apply one operation to the shadow list and return its result
	function automatic list_result_t list_apply(input logic [OP_W-1:0] op,
			input logic signed [VAL_W-1:0] val, input logic [POS_W-1:0] pos);
		list_result_t r;
		int at;
		r = '0;
		r.status = ST_DONE;
		case (op)
			OP_PUSH_BACK, OP_PUSH_FRONT, OP_INSERT: begin
				if (shadow_len >= LIST_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					if (op == OP_PUSH_BACK)
						at = shadow_len;
					else if (op == OP_PUSH_FRONT)
						at = 0;
					else
						at = (int'(pos) >= shadow_len) ? shadow_len : int'(pos);
					for (int k = shadow_len; k > at; k--)
						shadow_entries[k] = shadow_entries[k-1];
					shadow_entries[at] = val;
					shadow_len++;
				end
			end
			OP_POP_FRONT, OP_POP_BACK, OP_ERASE: begin
				if (shadow_len == 0) begin
					r.status = ST_EMPTY;
				end else begin
					if (op == OP_POP_FRONT)
						at = 0;
					else if (op == OP_POP_BACK)
						at = shadow_len - 1;
					else
						at = (int'(pos) >= shadow_len - 1) ? shadow_len - 1 : int'(pos);
					for (int k = at; k + 1 < shadow_len; k++)
						shadow_entries[k] = shadow_entries[k+1];
					shadow_len--;
				end
			end
			OP_SEARCH: begin
				for (int k = 0; k < shadow_len; k++) begin
					if (!r.found && shadow_entries[k] == val) begin
						r.found = 1'b1;
						r.fidx = FIDX_W'(k);
					end
				end
			end
			default: ;
		endcase
		r.len = LEN_W'(shadow_len);
		return r;
	endfunction

	// offer one item, wait for its transfer, record the expectation, then maybe idle
	task automatic offer(input logic [OP_W-1:0] op, input logic signed [VAL_W-1:0] val,
			input logic [POS_W-1:0] pos, input bit use_fixed, input list_result_t fixed);
		list_result_t predicted;
		int gap;
		@(negedge clk);
		in_valid = 1'b1;
		operation = op;
		value = val;
		position = pos;
		do @(posedge clk); while (in_stall);
		predicted = list_apply(op, val, pos);
		pending_results.push_back(use_fixed ? fixed : predicted);
		items_accepted++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
				: $urandom_range(0, 20);
			if (!rx_holding) begin
				gap = $urandom_range(1, 8);
				@(negedge clk);
				in_valid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
	endtask

	task automatic check_field(input string field, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_v, act_v);
			mismatch_count++;
		end
	endtask

	// result side: compare every transfer with the oldest expectation
	always @(posedge clk) begin
		list_result_t head;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, got status %0d length %0d",
					$time, status, length);
				mismatch_count++;
			end else begin
				head = pending_results[0];
				pending_results.delete(0);
				check_field("status", head.status, status);
				check_field("found", head.found, found);
				check_field("found_index", head.fidx, found_index);
				check_field("length", head.len, length);
			end
		end
	end

	// receiver stall pattern, with one long hold-off to back the block up
	initial begin
		int mode;
		int mode_left;
		bit hold_done;
		out_stall = 1'b0;
		rx_holding = 1'b0;
		hold_done = 1'b0;
		mode = 0;
		mode_left = 100;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!hold_done && items_accepted >= HOLD_AFTER) begin
				hold_done = 1'b1;
				rx_holding = 1'b1;
				out_stall = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				rx_holding = 1'b0;
			end
			case (mode)
				0: out_stall = 1'b0;
				1: out_stall = ($urandom_range(0, 99) < 30);
				2: out_stall = ($urandom_range(0, 99) < 75);
				default: out_stall = ~out_stall;
			endcase
			mode_left--;
			if (mode_left == 0) begin
				mode = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 150);
			end
		end
	end

	// stimulus: directed table, then shaped random traffic
	initial begin
		dir_row_t row;
		list_result_t typed_res;
		logic [OP_W-1:0] op;
		logic signed [VAL_W-1:0] val;
		logic [POS_W-1:0] pos;
		int mix;
		int mix_left;
		int grow_pct;
		int search_pct;
		int roll;
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = '0;
		value = '0;
		position = '0;
		shadow_len = 0;
		mismatch_count = 0;
		items_accepted = 0;
		burst_left = 0;
		foreach (shadow_entries[i])
			shadow_entries[i] = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < $size(DIR_TABLE); i++) begin
			row = DIR_TABLE[i];
			typed_res = {row.st, row.fnd, row.fidx, row.len};
			for (int j = 0; j < int'(row.reps); j++)
				offer(row.op, row.val + j, row.pos, row.fixed_exp, typed_res);
		end

		// phases lean toward filling, draining, mixing or searching
		mix = 0;
		mix_left = 0;
		typed_res = '0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (mix_left == 0) begin
				mix = $urandom_range(0, 3);
				mix_left = $urandom_range(20, 80);
			end
			mix_left--;
			grow_pct = (mix == 0) ? 80 : (mix == 1) ? 20 : 50;
			search_pct = (mix == 3) ? 50 : 15;

			roll = $urandom_range(0, 99);
			if (roll < 4)
				op = OP_UNUSED;
			else if (roll < search_pct)
				op = OP_SEARCH;
			else if ($urandom_range(0, 99) < grow_pct)
				op = OP_W'(OP_PUSH_BACK + $urandom_range(0, 2));
			else
				op = OP_W'(OP_POP_FRONT + $urandom_range(0, 2));

			// values: stored ones, small duplicates, extremes, anything
			roll = $urandom_range(0, 99);
			if (roll < 40 && shadow_len > 0)
				val = shadow_entries[$urandom_range(0, shadow_len - 1)];
			else if (roll < 65)
				val = $signed($urandom_range(0, 6)) - 3;
			else if (roll < 75)
				case ($urandom_range(0, 3))
					0: val = 32'sh7FFFFFFF;
					1: val = 32'sh80000000;
					2: val = 32'sh0;
					default: val = -32'sd1;
				endcase
			else
				val = $urandom;

			if ($urandom_range(0, 99) < 75)
				pos = POS_W'($urandom_range(0, shadow_len + 1));
			else
				pos = POS_W'($urandom_range(0, 255));

			offer(op, val, pos, 1'b0, typed_res);
		end

		@(negedge clk);
		in_valid = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// watchdog
	initial begin
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

[sim.f]
rtl/plist_pkg.sv
rtl/plist_cell.sv
rtl/positional_list_engine_top.sv
rtl/plist_chk.sv
sim/tb.sv
